// ===== hdl/nvpd_pkg.sv =====
// Package for the name-value pair decoder: phase codes, byte tags, state and result types.
// No dependencies; compiled first.
package nvpd_pkg;

  localparam int unsigned LenW = 31;

  localparam logic [2:0] PH_NAME_LEN       = 3'd0;
  localparam logic [2:0] PH_NAME_LEN_MORE  = 3'd1;
  localparam logic [2:0] PH_VALUE_LEN      = 3'd2;
  localparam logic [2:0] PH_VALUE_LEN_MORE = 3'd3;
  localparam logic [2:0] PH_NAME           = 3'd4;
  localparam logic [2:0] PH_VALUE          = 3'd5;

  localparam logic [1:0] KIND_LENGTH = 2'd0;
  localparam logic [1:0] KIND_NAME   = 2'd1;
  localparam logic [1:0] KIND_VALUE  = 2'd2;

  localparam int unsigned LenLongBit   = 7;
  localparam logic [6:0]  LenLowMask   = 7'h7f;
  localparam logic [1:0]  LongLenLastIdx = 2'd3;  // four-byte length: three extra bytes

  typedef struct packed {
    logic [2:0]      phase;
    logic [1:0]      len_idx;
    logic [LenW-1:0] name_len;
    logic [LenW-1:0] value_len;
    logic [LenW-1:0] bytes_left;
  } state_t;

  typedef struct packed {
    logic [7:0]      byte_out;
    logic [1:0]      byte_kind;
    logic            field_end;
    logic            pair_end;
    logic [LenW-1:0] name_length_out;
    logic [LenW-1:0] value_length_out;
    logic            truncated;
    logic            record_end;
  } result_t;

endpackage

// ===== hdl/nvpd_if.sv =====
// Request and result channel interfaces of the name-value pair decoder.
// Depends on nvpd_pkg for the length width.
interface nvpd_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nvpd_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                byte_out;
  logic [1:0]                byte_kind;
  logic                      field_end;
  logic                      pair_end;
  logic [nvpd_pkg::LenW-1:0] name_length_out;
  logic [nvpd_pkg::LenW-1:0] value_length_out;
  logic                      truncated;
  logic                      record_end;

  modport source (output valid, output byte_out, output byte_kind, output field_end,
                  output pair_end, output name_length_out, output value_length_out,
                  output truncated, output record_end, input ready);
  modport sink   (input valid, input byte_out, input byte_kind, input field_end,
                  input pair_end, input name_length_out, input value_length_out,
                  input truncated, input record_end, output ready);
endinterface

// ===== hdl/name_value_pair_decoder_core.sv =====
// Top level of the name-value pair decoder: input register, decoder, result register.
// Depends on nvpd_pkg, nvpd_if, nvpd_decode and nvpd_out_reg.
//
//  channel  | modport        | moves per request
//  ---------+----------------+--------------------------------------------------
//  req_i    | nvpd_req_if    | one content byte + last-byte flag
//  rsp_o    | nvpd_rsp_if    | byte, tag, field/pair end, lengths, truncated, end
//
// One request in, one result out. A byte lands in the input register, then the
// decoder tags it and updates the pair state on the way into the result register.
// One byte per cycle is sustained while rsp_o does not stall; the per-byte
// state update (a 31-bit decrement and compare) sets the pace.
// Reset clears the pair state to "awaiting name length" and empties both stages.
// A stall on rsp_o holds the result register; the input register still takes
// one more byte, after which req_i.ready drops until a result is taken.
module name_value_pair_decoder_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  nvpd_req_if.sink         req_i,
  nvpd_rsp_if.source       rsp_o
);
  import nvpd_pkg::*;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic    out_can_load;
  logic    advance;       // byte moves from input register into decoder + result reg
  logic    req_fire;
  result_t dec_res;
  result_t out_res;

  assign advance     = in_valid_q && out_can_load;
  assign req_i.ready = !in_valid_q || advance;
  assign req_fire    = req_i.valid && req_i.ready;
  assign in_valid_d  = req_fire ? 1'b1 : (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_byte_q <= req_i.data_byte;
      in_last_q <= req_i.last_byte;
    end
  end

  // pair state lives here; it steps only when a byte advances
  nvpd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (advance),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .res_o       (dec_res)
  );

  nvpd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .res_i      (dec_res),
    .ready_i    (rsp_o.ready),
    .can_load_o (out_can_load),
    .valid_o    (rsp_o.valid),
    .res_o      (out_res)
  );

  assign rsp_o.byte_out         = out_res.byte_out;
  assign rsp_o.byte_kind        = out_res.byte_kind;
  assign rsp_o.field_end        = out_res.field_end;
  assign rsp_o.pair_end         = out_res.pair_end;
  assign rsp_o.name_length_out  = out_res.name_length_out;
  assign rsp_o.value_length_out = out_res.value_length_out;
  assign rsp_o.truncated        = out_res.truncated;
  assign rsp_o.record_end       = out_res.record_end;

endmodule

// ===== hdl/nvpd_decode.sv =====
// Pair decoder state and per-byte next-state / tag logic.
// Depends on nvpd_pkg.
module nvpd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output nvpd_pkg::result_t res_o
);
  import nvpd_pkg::*;

  state_t st_q, st_d, upd;
  logic              is_long;
  logic [1:0]        idx_inc;
  logic [LenW-1:0]   dec;
  logic              pend;
  logic              fend;
  logic [1:0]        kind;
  logic [LenW-1:0]   short_len;
  logic [LenW-1:0]   long_first;

  assign is_long    = data_byte_i[LenLongBit];
  assign idx_inc    = st_q.len_idx + 2'd1;
  assign dec        = st_q.bytes_left - LenW'(1);
  assign short_len  = LenW'(data_byte_i);
  assign long_first = LenW'(data_byte_i[6:0] & LenLowMask);

  always_comb begin
    upd  = st_q;
    pend = 1'b0;
    fend = 1'b0;
    kind = KIND_LENGTH;
    unique case (st_q.phase) inside
      PH_NAME_LEN_MORE: begin
        upd.name_len = {st_q.name_len[LenW-9:0], data_byte_i};
        upd.len_idx  = idx_inc;
        if (idx_inc >= LongLenLastIdx) begin
          upd.len_idx = 2'd0;
          upd.phase   = PH_VALUE_LEN;
        end
      end
      PH_VALUE_LEN, PH_VALUE_LEN_MORE: begin
        if (st_q.phase == PH_VALUE_LEN) begin
          upd.value_len = is_long ? long_first : short_len;
          upd.len_idx   = 2'd0;
        end else begin
          upd.value_len = {st_q.value_len[LenW-9:0], data_byte_i};
          upd.len_idx   = idx_inc;
        end
        // both lengths known: pick first data phase, or close the pair if both are zero
        if ((st_q.phase == PH_VALUE_LEN && !is_long) ||
            (st_q.phase == PH_VALUE_LEN_MORE && idx_inc >= LongLenLastIdx)) begin
          upd.len_idx = 2'd0;
          if (upd.name_len != '0) begin
            upd.phase      = PH_NAME;
            upd.bytes_left = upd.name_len;
          end else if (upd.value_len != '0) begin
            upd.phase      = PH_VALUE;
            upd.bytes_left = upd.value_len;
          end else begin
            upd.phase = PH_NAME_LEN;
            pend      = 1'b1;
          end
        end else if (st_q.phase == PH_VALUE_LEN) begin
          upd.phase = PH_VALUE_LEN_MORE;
        end
      end
      PH_NAME: begin
        kind           = KIND_NAME;
        upd.bytes_left = dec;
        if (dec == '0) begin
          fend = 1'b1;
          if (st_q.value_len != '0) begin
            upd.phase      = PH_VALUE;
            upd.bytes_left = st_q.value_len;
          end else begin
            pend      = 1'b1;
            upd.phase = PH_NAME_LEN;
          end
        end
      end
      PH_VALUE: begin
        kind           = KIND_VALUE;
        upd.bytes_left = dec;
        if (dec == '0) begin
          fend      = 1'b1;
          pend      = 1'b1;
          upd.phase = PH_NAME_LEN;
        end
      end
      default: begin  // awaiting name length; unused codes land here too
        upd.value_len = '0;
        upd.len_idx   = 2'd0;
        upd.name_len  = is_long ? long_first : short_len;
        upd.phase     = is_long ? PH_NAME_LEN_MORE : PH_VALUE_LEN;
      end
    endcase
  end

  always_comb begin
    res_o.byte_out         = data_byte_i;
    res_o.byte_kind        = kind;
    res_o.field_end        = fend;
    res_o.pair_end         = pend;
    res_o.name_length_out  = upd.name_len;
    res_o.value_length_out = upd.value_len;
    res_o.truncated        = last_byte_i & ~pend;
    res_o.record_end       = last_byte_i;
  end

  always_comb begin
    st_d = st_q;
    if (take_i) begin
      st_d = last_byte_i ? '0 : upd;  // record end: back to reset state
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  // data phases always have bytes still owed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_NAME || st_q.phase == PH_VALUE) |-> st_q.bytes_left != '0)
    else $error("data phase with zero bytes left");

  // extra-length counter only moves while a long length is arriving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.phase == PH_NAME_LEN_MORE || st_q.phase == PH_VALUE_LEN_MORE) |->
      st_q.len_idx == 2'd0)
    else $error("length byte index left nonzero");

  // closing byte of a record returns the decoder to its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && last_byte_i) |=> (st_q.phase == PH_NAME_LEN && st_q.name_len == '0))
    else $error("state not cleared after record end");

  // value phase never entered with a zero value length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_VALUE |-> st_q.value_len != '0)
    else $error("value phase with empty value");

endmodule

// ===== hdl/nvpd_out_reg.sv =====
// Result register of the decoder with valid/ready toward the sink.
// Depends on nvpd_pkg.
module nvpd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  nvpd_pkg::result_t res_i,
  input  logic              ready_i,
  output logic              can_load_o,
  output logic              valid_o,
  output nvpd_pkg::result_t res_o
);
  import nvpd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_d    = load_i ? 1'b1 : (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

// ===== tb/tb_name_value_pair_decoder_core.sv =====
`timescale 1ns / 100ps
// Self-checking bench for name_value_pair_decoder_core: pair-state tracker plus tag queue.
// Depends on nvpd_pkg, nvpd_if and the RTL of the decoder; nothing else.
import nvpd_pkg::*;

class nvpd_scoreboard;
  logic [2:0]      phase;
  logic [1:0]      len_idx;
  logic [LenW-1:0] name_len;
  logic [LenW-1:0] value_len;
  logic [LenW-1:0] bytes_left;
  result_t         expected_tags_q[$];
  int unsigned     mismatches;

  function new();
    mismatches = 0;
    clear_pair_state();
  endfunction

  function void clear_pair_state();
    phase      = PH_NAME_LEN;
    len_idx    = '0;
    name_len   = '0;
    value_len  = '0;
    bytes_left = '0;
  endfunction

  // Both lengths known: move to the first non-empty field; 1 when the pair is already done
  function bit start_fields();
    if (name_len != '0) begin
      phase      = PH_NAME;
      bytes_left = name_len;
      return 1'b0;
    end
    if (value_len != '0) begin
      phase      = PH_VALUE;
      bytes_left = value_len;
      return 1'b0;
    end
    phase = PH_NAME_LEN;
    return 1'b1;
  endfunction

  // Tags one accepted request byte and queues the expected result
  function void decode_request(logic [7:0] data, logic last_flag);
    result_t tag;
    logic    long_form;
    tag           = '0;
    tag.byte_out  = data;
    tag.byte_kind = KIND_LENGTH;
    long_form     = data[LenLongBit];
    case (phase)
      PH_NAME_LEN_MORE: begin
        name_len = {name_len[LenW-9:0], data};
        len_idx  = len_idx + 2'd1;
        if (len_idx >= LongLenLastIdx) begin
          len_idx = '0;
          phase   = PH_VALUE_LEN;
        end
      end
      PH_VALUE_LEN: begin
        if (long_form) begin
          value_len = LenW'(data[6:0] & LenLowMask);
          len_idx   = '0;
          phase     = PH_VALUE_LEN_MORE;
        end else begin
          value_len    = LenW'(data);
          tag.pair_end = start_fields();
        end
      end
      PH_VALUE_LEN_MORE: begin
        value_len = {value_len[LenW-9:0], data};
        len_idx   = len_idx + 2'd1;
        if (len_idx >= LongLenLastIdx) begin
          len_idx      = '0;
          tag.pair_end = start_fields();
        end
      end
      PH_NAME: begin
        tag.byte_kind = KIND_NAME;
        bytes_left    = bytes_left - LenW'(1);
        if (bytes_left == '0) begin
          tag.field_end = 1'b1;
          if (value_len != '0) begin
            phase      = PH_VALUE;
            bytes_left = value_len;
          end else begin
            tag.pair_end = 1'b1;
            phase        = PH_NAME_LEN;
          end
        end
      end
      PH_VALUE: begin
        tag.byte_kind = KIND_VALUE;
        bytes_left    = bytes_left - LenW'(1);
        if (bytes_left == '0) begin
          tag.field_end = 1'b1;
          tag.pair_end  = 1'b1;
          phase         = PH_NAME_LEN;
        end
      end
      default: begin
        // start of a pair; unused phase codes fall here as well
        value_len = '0;
        len_idx   = '0;
        if (long_form) begin
          name_len = LenW'(data[6:0] & LenLowMask);
          phase    = PH_NAME_LEN_MORE;
        end else begin
          name_len = LenW'(data);
          phase    = PH_VALUE_LEN;
        end
      end
    endcase
    tag.truncated        = last_flag && !tag.pair_end;
    tag.name_length_out  = name_len;
    tag.value_length_out = value_len;
    tag.record_end       = last_flag;
    if (last_flag) clear_pair_state();
    expected_tags_q.insert(expected_tags_q.size(), tag);
  endfunction

  function void compare_field(string field, logic [LenW-1:0] want, logic [LenW-1:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
      mismatches++;
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_tags_q.size() == 0) begin
      $error("result with nothing outstanding: byte_out 0x%0h", got.byte_out);
      mismatches++;
      return;
    end
    want = expected_tags_q.pop_front();
    compare_field("byte_out", LenW'(want.byte_out), LenW'(got.byte_out));
    compare_field("byte_kind", LenW'(want.byte_kind), LenW'(got.byte_kind));
    compare_field("field_end", LenW'(want.field_end), LenW'(got.field_end));
    compare_field("pair_end", LenW'(want.pair_end), LenW'(got.pair_end));
    compare_field("name_length_out", want.name_length_out, got.name_length_out);
    compare_field("value_length_out", want.value_length_out, got.value_length_out);
    compare_field("truncated", LenW'(want.truncated), LenW'(got.truncated));
    compare_field("record_end", LenW'(want.record_end), LenW'(got.record_end));
  endfunction

  function int unsigned pending();
    return expected_tags_q.size();
  endfunction
endclass

module tb_name_value_pair_decoder_core;

  localparam int unsigned ItemTarget     = 950;
  localparam int unsigned IdleLimit      = 1000;  // cycles with no request or result moving
  localparam int unsigned LongHoldCycles = 60;    // receiver back-pressure burst
  localparam int unsigned DrainCycles    = 10;    // settle time after the last result

  logic clk_i = 1'b0;
  logic rst_ni;

  nvpd_req_if req_if ();
  nvpd_rsp_if rsp_if ();

  nvpd_scoreboard pair_tracker = new();

  logic [7:0]  rec_q[$];        // content bytes of the record being sent
  int unsigned requests_sent = 0;
  int unsigned idle_cycles = 0;
  bit          src_no_gaps = 1'b0;
  bit          sink_no_stalls = 1'b0;
  bit          hold_rsp_pending = 1'b0;  // raised by the stimulus, consumed by the sink

  name_value_pair_decoder_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Offer one byte after a random gap and hold it until the decoder takes it.
  // valid is only touched once per edge: lowered for a gap, or re-driven high.
  task automatic send_byte(input logic [7:0] data, input logic last_flag);
    int unsigned gap;
    gap = src_no_gaps ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.data_byte <= data;
    req_if.last_byte <= last_flag;
    do @(posedge clk_i); while (!req_if.ready);
    pair_tracker.decode_request(data, last_flag);
    requests_sent++;
  endtask

  // Whole record; the flag goes on its final byte
  task automatic send_record();
    foreach (rec_q[i]) send_byte(rec_q[i], i == rec_q.size() - 1);
  endtask

  // Sender goes quiet until every outstanding tag has come back
  task automatic pause_until_drained();
    req_if.valid <= 1'b0;
    while (pair_tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Appends one byte at the tail of the record
  function automatic void queue_byte(logic [7:0] b);
    rec_q.insert(rec_q.size(), b);
  endfunction

  // Length in wire form: one byte, or four bytes big-endian with the top bit set
  function automatic void add_length(int unsigned len, bit long_form);
    if (long_form) begin
      queue_byte({1'b1, len[30:24]});
      queue_byte(len[23:16]);
      queue_byte(len[15:8]);
      queue_byte(len[7:0]);
    end else begin
      queue_byte(len[7:0]);
    end
  endfunction

  function automatic void add_random_bytes(int unsigned n);
    repeat (n) queue_byte(8'($urandom));
  endfunction

  // Mostly short fields; returns 1 for a length too large to ever send in full
  function automatic bit pick_length(output int unsigned len, output bit long_form);
    int unsigned roll;
    roll      = $urandom_range(0, 19);
    long_form = (roll >= 17);
    if (roll < 3) len = 0;
    else if (roll < 15) len = $urandom_range(1, 6);
    else if (roll < 17) len = $urandom_range(7, 127);
    else if (roll < 19) len = $urandom_range(0, 6);
    else len = $urandom_range(256, 32'h7fff_ffff);
    return roll == 19;
  endfunction

  // Well-formed pairs with random content; some records are noise, some cut short
  function automatic void build_random_record();
    int unsigned pairs;
    int unsigned name_n;
    int unsigned value_n;
    int unsigned cut;
    bit          name_long;
    bit          value_long;
    bit          name_big;
    bit          value_big;
    rec_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      add_random_bytes($urandom_range(1, 12));
      return;
    end
    pairs = $urandom_range(1, 4);
    repeat (pairs) begin
      name_big  = pick_length(name_n, name_long);
      value_big = pick_length(value_n, value_long);
      add_length(name_n, name_long);
      add_length(value_n, value_long);
      if (name_big || value_big) begin
        // huge field: the record necessarily ends before that field is complete
        add_random_bytes($urandom_range(0, 5));
        return;
      end
      add_random_bytes(name_n);
      add_random_bytes(value_n);
    end
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(0, rec_q.size() - 1);
      while (rec_q.size() > cut + 1) void'(rec_q.pop_back());
    end
  endfunction

  // Result side: random stalls, plus one long hold-off when the stimulus asks
  initial begin : result_sink
    int unsigned stall;
    result_t     got;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_rsp_pending) begin
        stall            = LongHoldCycles;
        hold_rsp_pending = 1'b0;
      end else begin
        stall = sink_no_stalls ? 0 : $urandom_range(0, 4);
      end
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      got.byte_out         = rsp_if.byte_out;
      got.byte_kind        = rsp_if.byte_kind;
      got.field_end        = rsp_if.field_end;
      got.pair_end         = rsp_if.pair_end;
      got.name_length_out  = rsp_if.name_length_out;
      got.value_length_out = rsp_if.value_length_out;
      got.truncated        = rsp_if.truncated;
      got.record_end       = rsp_if.record_end;
      pair_tracker.check_result(got);
    end
  end

  // Watchdog: any long spell with no handshake on either channel is a hang
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned rec_idx;
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.data_byte <= '0;
    req_if.last_byte <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short name, value byte at the top of the range, pair closes the record
    rec_q = '{8'h01, 8'h01, 8'h00, 8'hff};
    send_record();
    // four-byte name length, empty value: pair ends on the last name byte
    rec_q = '{8'h80, 8'h00, 8'h00, 8'h02, 8'h00, 8'h5a, 8'ha5};
    send_record();
    // both lengths in long form and zero: pair ends on the last length byte
    rec_q = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00};
    send_record();
    // largest name length, largest short value length, record cut in the name
    rec_q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h11};
    send_record();
    // lone byte: the record ends waiting for the value length
    rec_q = '{8'h00};
    send_record();

    rec_idx = 0;
    while (requests_sent < ItemTarget) begin
      src_no_gaps    = ($urandom_range(0, 3) == 0);
      sink_no_stalls = ($urandom_range(0, 3) == 0);
      if (rec_idx == 3) begin
        // back-to-back bytes against a stalled receiver: both stages fill, req_i stalls
        hold_rsp_pending = 1'b1;
        src_no_gaps      = 1'b1;
        rec_q.delete();
        add_length(10, 1'b0);
        add_length(12, 1'b0);
        add_random_bytes(22);
      end else begin
        build_random_record();
      end
      send_record();
      if (rec_idx == 6) pause_until_drained();
      rec_idx++;
    end

    pause_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (pair_tracker.mismatches == 0 && pair_tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
